[rtl/pfbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbp_pkg: shared types and constants for the 2bpp framebuffer plotter
// Frame geometry, action codes, pixel masks and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package pfbp_pkg;

	// frame geometry
	localparam int ROW_BYTES   = 160;
	localparam int ROW_COUNT   = 192;
	localparam int STORE_BYTES = ROW_BYTES * ROW_COUNT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	typedef logic [1:0]        action_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// action codes
	localparam action_t ACT_SET  = 2'd0;
	localparam action_t ACT_XOR  = 2'd1;
	localparam action_t ACT_RUN  = 2'd2;
	localparam action_t ACT_READ = 2'd3;

	// per-slot masks, slot 0 is bits 7..6
	localparam logic [7:0] KEEP_MASK [4] = '{8'h3F, 8'hCF, 8'hF3, 8'hFC};
	localparam logic [7:0] PIX_MASK  [4] = '{8'hC0, 8'h30, 8'h0C, 8'h03};

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch a new item
		logic calc;      // form byte address, restart cursor on a first run
		logic rd;        // read the addressed byte
		logic wr_pix;    // write back the modified pixel byte
		logic run_step;  // write one run byte, advance cursor
		logic clr_step;  // clear one byte after reset
		logic finish;    // present the result
	} pfbp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t action;
		logic    clr_last;
		logic    count_zero;
	} pfbp_stat_t;

endpackage

[rtl/pfbp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbp_ctrl: plotter sequencer
// Runs the clearing sweep after reset, then steps each action through
// address, read, modify-write or run loop, and issues the result.
// ----------------------------------------------------------------------------
module pfbp_ctrl
	import pfbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  pfbp_stat_t stat,
	output pfbp_cmd_t  cmd,
	output logic       busy
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CALC  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = (stat.action == ACT_RUN) ? ST_RUN : ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				cmd.wr_pix = (stat.action == ACT_SET) || (stat.action == ACT_XOR);
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RUN: begin
				if (stat.count_zero) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.run_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/pfbp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbp_datapath: frame store, run cursor and pixel modify logic
// Holds the 30720-byte frame memory (one write, one registered read),
// the latched item, the byte address and the result register.
// ----------------------------------------------------------------------------
module pfbp_datapath
	import pfbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pfbp_cmd_t  cmd,
	input  action_t    action,
	input  logic [9:0] pix_x,
	input  logic [7:0] pix_y,
	input  logic [1:0] color,
	input  logic [8:0] run_count,
	input  logic [7:0] run_value,
	input  logic       first_run,
	output pfbp_stat_t stat,
	output logic [7:0] read_data,
	output logic       done_res,
	output logic       res_strobe
);

	localparam addr_t LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	// latched item
	action_t    action_q;
	logic [9:0] pix_x_q;
	logic [7:0] pix_y_q;
	logic [1:0] color_q;
	logic [8:0] count_q;
	logic [7:0] value_q;
	logic       first_q;

	addr_t      addr_q;
	logic       ok_q;
	addr_t      cursor_q;
	addr_t      clr_addr_q;
	logic [7:0] rdata_q;
	logic [7:0] read_data_q;
	logic       strobe_q;

	logic [7:0] mem_q [STORE_BYTES];

	logic [7:0] col;
	logic [1:0] sub;
	logic [7:0] pix_byte;
	logic       mem_we;
	addr_t      mem_waddr;
	logic [7:0] mem_wdata;

	// item capture; count also steps down during a run
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			pix_x_q  <= pix_x;
			pix_y_q  <= pix_y;
			color_q  <= color;
			value_q  <= run_value;
			first_q  <= first_run;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)          count_q <= run_count;
		else if (cmd.run_step) count_q <= count_q - 9'd1;
	end

	// byte address of the pixel and on-screen check
	assign col = pix_x_q[9:2];
	assign sub = pix_x_q[1:0];

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			addr_q <= ADDR_W'(32'(pix_y_q) * 32'(ROW_BYTES) + 32'(col));
			ok_q   <= (32'(col) < ROW_BYTES) && (32'(pix_y_q) < ROW_COUNT);
		end
	end

	// run cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (cmd.calc && (action_q == ACT_RUN) && first_q) begin
			cursor_q <= '0;
		end else if (cmd.run_step) begin
			cursor_q <= (cursor_q == LAST_ADDR) ? '0 : cursor_q + 1'b1;
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           clr_addr_q <= '0;
		else if (cmd.clr_step) clr_addr_q <= clr_addr_q + 1'b1;
	end

	// modified pixel byte
	always_comb begin
		if (action_q == ACT_XOR) pix_byte = rdata_q ^ PIX_MASK[sub];
		else pix_byte = (rdata_q & KEEP_MASK[sub]) | ({4{color_q}} & PIX_MASK[sub]);
	end

	// write port select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = pix_byte;
		if (cmd.clr_step) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = 8'h00;
		end else if (cmd.run_step) begin
			mem_we    = 1'b1;
			mem_waddr = cursor_q;
			mem_wdata = value_q;
		end else if (cmd.wr_pix) begin
			mem_we = ok_q;
		end
	end

	// frame memory
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rdata_q <= mem_q[addr_q];
	end

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q    <= 1'b0;
			read_data_q <= 8'h00;
		end else begin
			strobe_q    <= cmd.finish;
			read_data_q <= (cmd.finish && (action_q == ACT_READ) && ok_q) ? rdata_q : 8'h00;
		end
	end

	assign stat.action     = action_q;
	assign stat.clr_last   = (clr_addr_q == LAST_ADDR);
	assign stat.count_zero = (count_q == 9'd0);

	assign read_data  = read_data_q;
	assign done_res   = strobe_q;
	assign res_strobe = strobe_q;

endmodule

[rtl/packed_2bpp_framebuffer_plotter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_2bpp_framebuffer_plotter_top: 640x192 2bpp framebuffer plotter
// Set, xor and read pixels, or write run-length runs at a wrapping cursor.
// ----------------------------------------------------------------------------
// Set, xor, read: busy from accept through address, memory read and
//   modify-write; a new item is taken only once the last is through.
// Run of N bytes: one memory write per cycle; the result strobe is
//   registered once the count reaches zero, and busy holds off the next item.
// Reset: busy stays high while the frame memory is swept to zero,
//   one byte per cycle. Results cannot be stalled.
module packed_2bpp_framebuffer_plotter_top
	import pfbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [9:0] pix_x,
	input  logic [7:0] pix_y,
	input  logic [1:0] color,
	input  logic [8:0] run_count,
	input  logic [7:0] run_value,
	input  logic       first_run,
	output logic       res_strobe,
	output logic [7:0] read_data,
	output logic       done_res
);

	pfbp_cmd_t  cmd;
	pfbp_stat_t stat;

	pfbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pfbp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.color      (color),
		.run_count  (run_count),
		.run_value  (run_value),
		.first_run  (first_run),
		.stat       (stat),
		.read_data  (read_data),
		.done_res   (done_res),
		.res_strobe (res_strobe)
	);

endmodule

[rtl/pfbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbp_checker: port-level checks for the plotter
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module pfbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] action,
	input logic [9:0] pix_x,
	input logic [7:0] pix_y,
	input logic [1:0] color,
	input logic [8:0] run_count,
	input logic [7:0] run_value,
	input logic       first_run,
	input logic       res_strobe,
	input logic [7:0] read_data,
	input logic       done_res
);

	// an accepted transfer makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	// result strobe is a single cycle
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |=> !res_strobe)
		else $error("result strobe held longer than one cycle");

	// results come only out of a busy period
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// outputs are quiet between results
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!res_strobe |-> (read_data == 8'h00) && !done_res)
		else $error("result ports active without strobe");

endmodule

bind packed_2bpp_framebuffer_plotter_top pfbp_checker u_chk (.*);

[test/packed_2bpp_framebuffer_plotter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_2bpp_framebuffer_plotter_top_tb: self-checking bench for the plotter
// Drives set, xor, run and read commands through the start/busy handshake.
// A scoreboard keeps its own copy of the frame and run cursor, predicts the
// result of every accepted command and compares each strobed result.
// ----------------------------------------------------------------------------
module packed_2bpp_framebuffer_plotter_top_tb;
	import pfbp_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 8;

	// one command as driven on the ports
	typedef struct {
		action_t    action;
		logic [9:0] pix_x;
		logic [7:0] pix_y;
		logic [1:0] color;
		logic [8:0] run_count;
		logic [7:0] run_value;
		logic       first_run;
	} plot_cmd_t;

	// one result as seen on the ports
	typedef struct {
		logic [7:0] read_data;
		logic       done_res;
	} plot_result_t;

	// ------------------------------------------------------------------
	// frame shadow, cursor and queue of awaited results
	// ------------------------------------------------------------------
	class plot_scoreboard;
		logic [7:0]   frame_bytes [STORE_BYTES];
		int unsigned  cursor;
		plot_result_t awaited_results [$];
		int           mismatches;

		function new();
			foreach (frame_bytes[i])
				frame_bytes[i] = 8'h00;
			cursor     = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// apply an accepted command to the shadow frame, queue its result
		function void note_command(plot_cmd_t cmd);
			int unsigned  col;
			int unsigned  row;
			int unsigned  addr;
			logic [1:0]   slot;
			logic         on_screen;
			plot_result_t res;
			col       = 32'(cmd.pix_x >> 2);
			row       = 32'(cmd.pix_y);
			slot      = cmd.pix_x[1:0];
			on_screen = (col < ROW_BYTES) && (row < ROW_COUNT);
			addr      = row * ROW_BYTES + col;
			res.read_data = 8'h00;
			res.done_res  = 1'b1;
			case (cmd.action)
				ACT_SET: begin
					if (on_screen)
						frame_bytes[addr] = (frame_bytes[addr] & KEEP_MASK[slot]) |
							({4{cmd.color}} & PIX_MASK[slot]);
				end
				ACT_XOR: begin
					if (on_screen)
						frame_bytes[addr] = frame_bytes[addr] ^ PIX_MASK[slot];
				end
				ACT_RUN: begin
					if (cmd.first_run)
						cursor = 0;
					if (cursor >= STORE_BYTES)
						cursor = 0;
					for (int i = 0; i < cmd.run_count; i++) begin
						frame_bytes[cursor] = cmd.run_value;
						cursor++;
						if (cursor >= STORE_BYTES)
							cursor = 0;
					end
				end
				default: begin
					if (on_screen)
						res.read_data = frame_bytes[addr];
				end
			endcase
			awaited_results.push_back(res);
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] ERROR %s", $time, msg);
			mismatches++;
		endtask

		// compare one strobed result with the oldest awaited one
		task check_result(logic [7:0] read_data, logic done_res);
			plot_result_t want;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result read_data=%h done_res=%b",
					read_data, done_res));
				return;
			end
			want = awaited_results.pop_front();
			if (read_data !== want.read_data)
				report_mismatch($sformatf("read_data %h, want %h", read_data, want.read_data));
			if (done_res !== want.done_res)
				report_mismatch($sformatf("done_res %b, want %b", done_res, want.done_res));
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT ports
	// ------------------------------------------------------------------
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic       busy;
	logic [1:0] action     = ACT_READ;
	logic [9:0] pix_x      = '0;
	logic [7:0] pix_y      = '0;
	logic [1:0] color      = '0;
	logic [8:0] run_count  = '0;
	logic [7:0] run_value  = '0;
	logic       first_run  = 1'b0;
	logic       res_strobe;
	logic [7:0] read_data;
	logic       done_res;

	plot_scoreboard sb;
	int             cycle_count = 0;
	logic [9:0]     hot_x = '0;
	logic [7:0]     hot_y = '0;

	packed_2bpp_framebuffer_plotter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.color      (color),
		.run_count  (run_count),
		.run_value  (run_value),
		.first_run  (first_run),
		.res_strobe (res_strobe),
		.read_data  (read_data),
		.done_res   (done_res)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// result monitor: a result is taken at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && res_strobe)
			sb.check_result(read_data, done_res);
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic plot_cmd_t make_cmd(action_t a, int x, int y, int c, int n, int v,
		int f);
		plot_cmd_t cmd;
		cmd.action    = a;
		cmd.pix_x     = 10'(x);
		cmd.pix_y     = 8'(y);
		cmd.color     = 2'(c);
		cmd.run_count = 9'(n);
		cmd.run_value = 8'(v);
		cmd.first_run = 1'(f);
		return cmd;
	endfunction

	// random command; pixels cluster near the top of the frame where runs land
	function automatic plot_cmd_t rand_cmd();
		plot_cmd_t cmd;
		int        r;
		cmd = make_cmd(action_t'($urandom_range(3)), $urandom_range(1023), $urandom_range(255),
			$urandom_range(3), $urandom_range(511), $urandom_range(255), $urandom_range(1));
		r = $urandom_range(99);
		if (r < 45) begin
			cmd.pix_x = 10'($urandom_range(63));
			cmd.pix_y = 8'($urandom_range(3));
		end else if (r < 60) begin
			cmd.pix_x = 10'($urandom_range(639));
			cmd.pix_y = 8'($urandom_range(3));
		end else if (r < 85) begin
			cmd.pix_x = 10'($urandom_range(639));
			cmd.pix_y = 8'($urandom_range(ROW_COUNT - 1));
		end
		r = $urandom_range(99);
		if (r < 30)
			cmd.action = ACT_SET;
		else if (r < 50)
			cmd.action = ACT_XOR;
		else if (r < 65)
			cmd.action = ACT_RUN;
		else
			cmd.action = ACT_READ;
		case (cmd.action)
			ACT_SET, ACT_XOR: begin
				hot_x = cmd.pix_x;
				hot_y = cmd.pix_y;
			end
			ACT_RUN: begin
				r = $urandom_range(99);
				if (r < 65)
					cmd.run_count = 9'($urandom_range(12));
				else if (r < 93)
					cmd.run_count = 9'($urandom_range(80));
				cmd.first_run = ($urandom_range(99) < 25);
			end
			default: begin
				// read back the last touched pixel half the time
				if ($urandom_range(1)) begin
					cmd.pix_x = hot_x;
					cmd.pix_y = hot_y;
				end
			end
		endcase
		return cmd;
	endfunction

	// present a command and hold it until the transfer
	task automatic send_cmd(plot_cmd_t cmd);
		action    <= cmd.action;
		pix_x     <= cmd.pix_x;
		pix_y     <= cmd.pix_y;
		color     <= cmd.color;
		run_count <= cmd.run_count;
		run_value <= cmd.run_value;
		first_run <= cmd.first_run;
		start     <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_command(cmd);
	endtask

	task automatic maybe_idle(int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic random_phase(int count, int idle_pct);
		for (int i = 0; i < count; i++) begin
			send_cmd(rand_cmd());
			maybe_idle(idle_pct);
		end
	endtask

	// hold off until every awaited result has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fresh frame, each slot, corners, off screen, runs
		send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 0, 0, 3, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 1, 0, 1, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 2, 0, 3, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 3, 0, 2, 0, 0, 0));
		send_cmd(make_cmd(ACT_READ, 2, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_XOR, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_XOR, 3, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 639, 191, 3, 0, 0, 0));
		send_cmd(make_cmd(ACT_READ, 636, 191, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 640, 0, 3, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 0, 192, 3, 0, 0, 0));
		send_cmd(make_cmd(ACT_XOR, 1023, 255, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_READ, 1023, 255, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_READ, 640, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0, 0, 8'hAA, 1));
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0, 4, 8'h5A, 1));
		send_cmd(make_cmd(ACT_READ, 12, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_READ, 16, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0, 511, 8'hFF, 0));
		send_cmd(make_cmd(ACT_READ, 140, 3, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0, 256, 8'h00, 0));
		send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
		drain();

		// random, sender idles often, then very often
		random_phase(320, 20);
		drain();
		random_phase(300, 70);
		drain();

		// back-to-back long runs carry the cursor past the end of the frame
		for (int i = 0; i < 61; i++) begin
			send_cmd(make_cmd(ACT_RUN, $urandom_range(1023), $urandom_range(255),
				$urandom_range(3), 511, $urandom_range(255), 0));
			if (i % 10 == 9)
				send_cmd(make_cmd(ACT_READ, $urandom_range(639), $urandom_range(191),
					0, 0, 0, 0));
		end
		random_phase(240, 0);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
